// ===== src/adsc_pkg.sv =====
package adsc_pkg;

  // default size of one dma block in bytes
  localparam int unsigned BLOCK_BYTES_DEF = 32;

  // depth of the queue between front and back
  localparam int unsigned CMD_DEPTH = 2;

  // request type codes
  localparam logic [2:0] REQ_READ   = 3'd0;
  localparam logic [2:0] REQ_WRITE  = 3'd1;
  localparam logic [2:0] REQ_TICK   = 3'd2;
  localparam logic [2:0] REQ_SAMPLE = 3'd3;
  localparam logic [2:0] REQ_DSPINT = 3'd4;

  // register select codes
  localparam logic [3:0] SEL_DCR     = 4'd0;
  localparam logic [3:0] SEL_ADDR_HI = 4'd1;
  localparam logic [3:0] SEL_ADDR_LO = 4'd2;
  localparam logic [3:0] SEL_LEN     = 4'd3;
  localparam logic [3:0] SEL_BLKCNT  = 4'd4;
  localparam logic [3:0] SEL_CR      = 4'd5;
  localparam logic [3:0] SEL_VOLUME  = 4'd6;
  localparam logic [3:0] SEL_SMPCNT  = 4'd7;
  localparam logic [3:0] SEL_TRIGGER = 4'd8;

  // dsp control register bits
  localparam int unsigned DCR_AIDINT = 3;
  localparam int unsigned DCR_AIDMSK = 4;
  localparam int unsigned DCR_DSPINT = 7;
  localparam int unsigned DCR_DSPMSK = 8;
  // bits that never survive a write: dma, aram and dsp flags, both busy bits
  localparam logic [15:0] DCR_WR_CLEAR = 16'h06A8;

  // stream control register bits
  localparam int unsigned CR_PSTAT   = 0;
  localparam int unsigned CR_INTMSK  = 2;
  localparam int unsigned CR_INT     = 3;
  localparam int unsigned CR_INTVLD  = 4;
  localparam int unsigned CR_SCRESET = 5;
  localparam logic [6:0]  CR_MASK    = 7'h7F;

  localparam int unsigned LEN_EN = 15;

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_READ   = 3'd1,
    OP_WRITE  = 3'd2,
    OP_TICK   = 3'd3,
    OP_SAMPLE = 3'd4,
    OP_DSPINT = 3'd5
  } op_e;

  typedef enum logic [3:0] {
    RG_NONE    = 4'd0,
    RG_DCR     = 4'd1,
    RG_ADDR_HI = 4'd2,
    RG_ADDR_LO = 4'd3,
    RG_LEN     = 4'd4,
    RG_BLKCNT  = 4'd5,
    RG_CR      = 4'd6,
    RG_VOLUME  = 4'd7,
    RG_SMPCNT  = 4'd8,
    RG_TRIGGER = 4'd9
  } rg_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [3:0]  reg_sel;
    logic [31:0] wr_data;
    logic [15:0] left_sample;
    logic [15:0] right_sample;
  } in_t;

  typedef struct packed {
    logic [31:0] rd_data;
    logic        dsp_irq;
    logic        ai_irq;
    logic        fetch_valid;
    logic [31:0] fetch_addr;
    logic        stream_valid;
    logic [15:0] stream_left;
    logic [15:0] stream_right;
    logic [2:0]  dsp_control;
  } out_t;

  // classified command handed from front to back
  typedef struct packed {
    op_e         op;
    rg_e         rg;
    logic [31:0] wr_data;
    logic [15:0] left;
    logic [15:0] right;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== src/adsc_front.sv =====
module adsc_front (
  input  adsc_pkg::in_t      in_i,
  input  logic               push,
  output logic               full,
  input  adsc_pkg::q_status_t q_status_i,
  output logic               enq_o,
  output adsc_pkg::cmd_t     cmd_o
);
  import adsc_pkg::*;

  assign full  = q_status_i.full;
  assign enq_o = push && !q_status_i.full;

  always_comb begin
    cmd_o         = '0;
    cmd_o.wr_data = in_i.wr_data;
    case (in_i.req_type)
      REQ_READ:   cmd_o.op = OP_READ;
      REQ_WRITE:  cmd_o.op = OP_WRITE;
      REQ_TICK:   cmd_o.op = OP_TICK;
      REQ_SAMPLE: cmd_o.op = OP_SAMPLE;
      REQ_DSPINT: cmd_o.op = OP_DSPINT;
      default:    cmd_o.op = OP_NONE;
    endcase
    case (in_i.reg_sel)
      SEL_DCR:     cmd_o.rg = RG_DCR;
      SEL_ADDR_HI: cmd_o.rg = RG_ADDR_HI;
      SEL_ADDR_LO: cmd_o.rg = RG_ADDR_LO;
      SEL_LEN:     cmd_o.rg = RG_LEN;
      SEL_BLKCNT:  cmd_o.rg = RG_BLKCNT;
      SEL_CR:      cmd_o.rg = RG_CR;
      SEL_VOLUME:  cmd_o.rg = RG_VOLUME;
      SEL_SMPCNT:  cmd_o.rg = RG_SMPCNT;
      SEL_TRIGGER: cmd_o.rg = RG_TRIGGER;
      default:     cmd_o.rg = RG_NONE;
    endcase
    // big-endian samples turned around here
    cmd_o.left  = {in_i.left_sample[7:0], in_i.left_sample[15:8]};
    cmd_o.right = {in_i.right_sample[7:0], in_i.right_sample[15:8]};
  end

endmodule

// ===== src/adsc_fifo.sv =====
module adsc_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                enq_i,
  input  adsc_pkg::cmd_t      cmd_i,
  input  logic                deq_i,
  output adsc_pkg::cmd_t      cmd_o,
  output adsc_pkg::q_status_t status_o
);
  import adsc_pkg::*;

  localparam int unsigned PtrW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(CMD_DEPTH + 1);

  cmd_t            mem_q [CMD_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_enq, do_deq;

  assign do_enq = enq_i && (cnt_q != CntW'(CMD_DEPTH));
  assign do_deq = deq_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_enq) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_deq) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_enq && !do_deq) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_enq && do_deq) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_enq) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign cmd_o          = mem_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == CntW'(CMD_DEPTH));
  assign status_o.empty = (cnt_q == '0);

endmodule

// ===== src/adsc_back.sv =====
module adsc_back #(
  parameter int unsigned BlockBytes = adsc_pkg::BLOCK_BYTES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  adsc_pkg::cmd_t cmd_i,
  input  logic           cmd_valid_i,
  output logic           deq_o,
  output adsc_pkg::out_t out_o,
  output logic           out_valid_o,
  input  logic           pop_i
);
  import adsc_pkg::*;

  logic [15:0] dcr_q, dcr_d;
  logic [6:0]  cr_q, cr_d;
  logic [15:0] len_q, len_d;
  logic [14:0] blk_q, blk_d;
  logic [31:0] addr_q, addr_d;
  logic [15:0] sh_hi_q, sh_hi_d;
  logic [15:0] sh_lo_q, sh_lo_d;
  logic        hi_wr_q, hi_wr_d;
  logic        lo_wr_q, lo_wr_d;
  logic [31:0] scnt_q, scnt_d;
  logic [31:0] trig_q, trig_d;
  logic [15:0] vol_q, vol_d;
  logic        dsp_line_q, dsp_line_d;
  logic        ai_line_q, ai_line_d;
  logic        out_valid_q;
  out_t        out_q, res;
  logic        fire;
  logic [31:0] scnt_inc;
  logic [6:0]  cr_wr;

  assign fire  = cmd_valid_i && (!out_valid_q || pop_i);
  assign deq_o = fire;

  assign scnt_inc = scnt_q + 32'd1;
  assign cr_wr    = cmd_i.wr_data[6:0] & CR_MASK;

  always_comb begin
    dcr_d      = dcr_q;
    cr_d       = cr_q;
    len_d      = len_q;
    blk_d      = blk_q;
    addr_d     = addr_q;
    sh_hi_d    = sh_hi_q;
    sh_lo_d    = sh_lo_q;
    hi_wr_d    = hi_wr_q;
    lo_wr_d    = lo_wr_q;
    scnt_d     = scnt_q;
    trig_d     = trig_q;
    vol_d      = vol_q;
    dsp_line_d = dsp_line_q;
    ai_line_d  = ai_line_q;
    res        = '0;

    case (cmd_i.op)
      OP_READ: begin
        case (cmd_i.rg)
          RG_DCR:     res.rd_data = {16'd0, dcr_q};
          RG_ADDR_HI: res.rd_data = {16'd0, sh_hi_q};
          RG_ADDR_LO: res.rd_data = {16'd0, sh_lo_q};
          RG_LEN:     res.rd_data = {16'd0, len_q};
          RG_BLKCNT:  res.rd_data = {17'd0, blk_q};
          RG_CR:      res.rd_data = {25'd0, cr_q};
          RG_VOLUME:  res.rd_data = {16'd0, vol_q};
          RG_SMPCNT:  res.rd_data = scnt_q;
          RG_TRIGGER: res.rd_data = trig_q;
          default:    res.rd_data = '0;
        endcase
      end
      OP_WRITE: begin
        case (cmd_i.rg)
          RG_DCR: begin
            dcr_d      = cmd_i.wr_data[15:0] & ~DCR_WR_CLEAR;
            dsp_line_d = 1'b0;
          end
          RG_ADDR_HI: begin
            sh_hi_d = cmd_i.wr_data[15:0];
            if (lo_wr_q) begin
              hi_wr_d = 1'b0;
              lo_wr_d = 1'b0;
              addr_d  = {cmd_i.wr_data[15:0], sh_lo_q};
            end else begin
              hi_wr_d = 1'b1;
            end
          end
          RG_ADDR_LO: begin
            sh_lo_d = cmd_i.wr_data[15:0];
            if (hi_wr_q) begin
              hi_wr_d = 1'b0;
              lo_wr_d = 1'b0;
              addr_d  = {sh_hi_q, cmd_i.wr_data[15:0]};
            end else begin
              lo_wr_d = 1'b1;
            end
          end
          RG_LEN: begin
            len_d = cmd_i.wr_data[15:0];
            blk_d = cmd_i.wr_data[LEN_EN] ? cmd_i.wr_data[14:0] : '0;
          end
          RG_CR: begin
            cr_d = cr_wr;
            // writing the flag as one acknowledges it
            if (cr_wr[CR_INT]) begin
              cr_d[CR_INT] = 1'b0;
              ai_line_d    = 1'b0;
            end
            if (cr_wr[CR_SCRESET]) begin
              scnt_d           = '0;
              cr_d[CR_SCRESET] = 1'b0;
            end
          end
          RG_VOLUME:  vol_d  = cmd_i.wr_data[15:0];
          RG_TRIGGER: trig_d = cmd_i.wr_data;
          default: ;
        endcase
      end
      OP_TICK: begin
        if (len_q[LEN_EN]) begin
          if (blk_q == '0) begin
            addr_d            = {sh_hi_q, sh_lo_q};
            blk_d             = len_q[14:0];
            dcr_d[DCR_AIDINT] = 1'b1;
            if (dcr_q[DCR_AIDMSK]) begin
              dsp_line_d = 1'b1;
            end
          end else begin
            res.fetch_valid = 1'b1;
            res.fetch_addr  = addr_q;
            addr_d          = addr_q + 32'(BlockBytes);
            blk_d           = blk_q - 1'b1;
          end
        end
      end
      OP_SAMPLE: begin
        res.stream_valid = 1'b1;
        res.stream_left  = cmd_i.left;
        res.stream_right = cmd_i.right;
        if (cr_q[CR_PSTAT]) begin
          scnt_d = scnt_inc;
          if ((scnt_inc >= trig_q) && !cr_q[CR_INTVLD]) begin
            cr_d[CR_INT] = 1'b1;
            if (cr_q[CR_INTMSK]) begin
              ai_line_d = 1'b1;
            end
          end
        end
      end
      OP_DSPINT: begin
        dcr_d[DCR_DSPINT] = 1'b1;
        if (dcr_q[DCR_DSPMSK]) begin
          dsp_line_d = 1'b1;
        end
      end
      default: ;
    endcase

    res.dsp_irq     = dsp_line_d;
    res.ai_irq      = ai_line_d;
    res.dsp_control = dcr_d[2:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcr_q       <= '0;
      cr_q        <= '0;
      len_q       <= '0;
      blk_q       <= '0;
      addr_q      <= '0;
      sh_hi_q     <= '0;
      sh_lo_q     <= '0;
      hi_wr_q     <= 1'b0;
      lo_wr_q     <= 1'b0;
      scnt_q      <= '0;
      trig_q      <= '0;
      vol_q       <= '0;
      dsp_line_q  <= 1'b0;
      ai_line_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        dcr_q      <= dcr_d;
        cr_q       <= cr_d;
        len_q      <= len_d;
        blk_q      <= blk_d;
        addr_q     <= addr_d;
        sh_hi_q    <= sh_hi_d;
        sh_lo_q    <= sh_lo_d;
        hi_wr_q    <= hi_wr_d;
        lo_wr_q    <= lo_wr_d;
        scnt_q     <= scnt_d;
        trig_q     <= trig_d;
        vol_q      <= vol_d;
        dsp_line_q <= dsp_line_d;
        ai_line_q  <= ai_line_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

endmodule

// ===== src/audio_dma_and_stream_counter.sv =====
// audio interface register block: dsp control, audio dma walker, stream sample counter
//
// input channel: one beat per push while full is low. a beat is a register read or write,
// a dma block tick, a stream sample pair or a dsp interrupt event.
// result channel: one result beat per input beat, in order. the result is on out_data_o
// while empty is low and leaves on a cycle with pop high.
//
// a taken beat is decoded by the front and parked in the two-entry command queue; the back
// executes it once it reaches the head and the result slot is free or draining, and its
// result is captured in the result register.
// throughput: one beat per cycle while pop keeps draining the result register.
//
// stall: when pop stays low the result register holds, the back stops, the command queue
// fills with up to two more beats and then full rises. no beat is lost.
// reset: the control registers, the dma address and counters clear, the queue comes up empty.
module audio_dma_and_stream_counter #(
  parameter int unsigned BlockBytes = adsc_pkg::BLOCK_BYTES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  adsc_pkg::in_t  in_data_i,
  output logic           empty,
  input  logic           pop,
  output adsc_pkg::out_t out_data_o
);
  import adsc_pkg::*;

  // front to queue
  cmd_t      front_cmd;
  logic      front_enq;
  q_status_t q_status;

  // queue to back
  cmd_t      head_cmd;
  logic      back_deq;
  logic      out_valid;

  // front: handshake and decode of request type, register select, sample swap
  adsc_front u_front (
    .in_i       (in_data_i),
    .push       (push),
    .full       (full),
    .q_status_i (q_status),
    .enq_o      (front_enq),
    .cmd_o      (front_cmd)
  );

  // command queue lets the front keep taking beats while results wait
  adsc_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .enq_i    (front_enq),
    .cmd_i    (front_cmd),
    .deq_i    (back_deq),
    .cmd_o    (head_cmd),
    .status_o (q_status)
  );

  // back: register file, dma walker, sample counter, result register
  adsc_back #(
    .BlockBytes (BlockBytes)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .cmd_valid_i (!q_status.empty),
    .deq_o       (back_deq),
    .out_o       (out_data_o),
    .out_valid_o (out_valid),
    .pop_i       (pop)
  );

  assign empty = !out_valid;

  // a taken beat is always waiting in the queue on the next cycle
  a_push_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> !q_status.empty)
    else $error("accepted beat missing from command queue");

  // the back only executes when the result slot is free or draining
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (back_deq && out_valid) |-> pop)
    else $error("result overwritten before it was taken");

  // a result never carries both a fetch and a stream sample
  a_one_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(out_data_o.fetch_valid && out_data_o.stream_valid))
    else $error("fetch and stream in one result");

  // no fetch address without a fetch
  a_fetch_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_data_o.fetch_valid) |-> (out_data_o.fetch_addr == 32'd0))
    else $error("fetch address without fetch");

endmodule
